// ===== rtl/core/pid_controller_windup_clamp_macros.svh =====
// Assertion macros shared by the PID controller checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef PID_CONTROLLER_WINDUP_CLAMP_MACROS_SVH
`define PID_CONTROLLER_WINDUP_CLAMP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PIDWC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PIDWC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pidwc_pkg.sv =====
// Shared constants for the PID controller with windup clamp.
// No dependencies; used by the top level and by its checker.
package pidwc_pkg;

    // Default width of the drive output.
    localparam int DATA_WIDTH_DEF = 32;

    // Input field widths and the packed input tdata width.
    localparam int TGT_W      = 32;
    localparam int MEAS_W     = 32;
    localparam int DT_W       = 16;
    localparam int IN_TDATA_W = TGT_W + MEAS_W + DT_W;

    // Configuration port.
    localparam int GAIN_W    = 32;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_P_GAIN      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_I_GAIN      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_D_GAIN      = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_WINDUP_GAIN = CFG_IDX_W'(3);

    // Internal datapath widths.
    localparam int ERR_W  = MEAS_W + 1;      // target - measured, exact
    localparam int INT_W  = 48;              // integral, signed Q16.32
    localparam int LIM_W  = INT_W - 1;       // windup limit magnitude
    localparam int ETRM_W = INT_W + 2;       // error * dt with sign, plus headroom
    localparam int DQ_W   = 50;              // derivative quotient below the cap
    localparam int SUM_W  = 53;              // signed sum of the three terms

    localparam logic [INT_W-1:0] INT_MAX = {1'b0, {(INT_W-1){1'b1}}};
    localparam logic [INT_W-1:0] INT_MIN = {1'b1, {(INT_W-1){1'b0}}};
    localparam logic [DQ_W:0]    TERM_CAP = {1'b1, {DQ_W{1'b0}}};

endpackage

// ===== rtl/core/pidwc_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Unsigned operands; no package dependencies.
module pidwc_mul #(
    parameter int A_W = 33,
    parameter int B_W = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic               busy,
    output logic [A_W+B_W-1:0] prod
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [A_W-1:0]   mcand_reg;
    logic [P_W-1:0]   prod_reg, prod_next;
    logic [A_W:0]     psum;

    // One step: add the multiplicand when the low bit is set, then shift right.
    always_comb
    begin
        psum      = {1'b0, prod_reg[P_W-1:B_W]} + (prod_reg[0] ? {1'b0, mcand_reg} : '0);
        prod_next = {psum, prod_reg[B_W-1:1]};
    end

    // Step counter and busy flag.
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(B_W);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and product registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg <= a;
            prod_reg  <= {{A_W{1'b0}}, b};
        end
        else if (busy_reg)
        begin
            prod_reg <= prod_next;
        end
    end

    assign busy = busy_reg;
    assign prod = prod_reg;

endmodule

// ===== rtl/core/pidwc_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle, MSB first.
// Keeps the low quotient bits and a sticky flag for any bit above them.
module pidwc_div #(
    parameter int N_W = 64,
    parameter int D_W = 16,
    parameter int Q_W = 50
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           busy,
    output logic [Q_W-1:0] quot,
    output logic           ovf
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [N_W-1:0]   num_reg;
    logic [D_W-1:0]   den_reg;
    logic [D_W-1:0]   rem_reg, rem_next;
    logic [Q_W-1:0]   quot_reg;
    logic             ovf_reg;
    logic [D_W:0]     trial;
    logic [D_W+1:0]   dif;
    logic             qbit;

    // Bring in the next dividend bit and try to subtract the divisor.
    always_comb
    begin
        trial    = {rem_reg, num_reg[N_W-1]};
        dif      = {1'b0, trial} - {2'b00, den_reg};
        qbit     = ~dif[D_W+1];
        rem_next = qbit ? dif[D_W-1:0] : trial[D_W-1:0];
    end

    // Step counter and busy flag.
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(N_W);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Shift registers for dividend, remainder and quotient.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= dividend;
            den_reg  <= divisor;
            rem_reg  <= '0;
            quot_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (busy_reg)
        begin
            num_reg  <= {num_reg[N_W-2:0], 1'b0};
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[Q_W-2:0], qbit};
            ovf_reg  <= ovf_reg | quot_reg[Q_W-1];
        end
    end

    assign busy = busy_reg;
    assign quot = quot_reg;
    assign ovf  = ovf_reg;

endmodule

// ===== rtl/core/pid_controller_windup_clamp.sv =====
// PID controller step in Q16.16 with an anti-windup clamp on the integral. An update
// transfer (tuser low) raises m_tvalid once its result is ready. The input side reopens
// in that same cycle, so a new update can be taken while that result waits to be taken.
// The integral path sets the time: a 64-step division for the windup limit, started with
// the first multiplies, then a 32-step serial multiply by i_gain, plus the sequencing
// states. The derivative path (a 32-step serial multiply followed by a 64-step serial
// divide by dt) runs beside it and finishes earlier. A clear transfer (tuser high) zeroes
// the integral and yields no result. One item is in work at a time. A finished result
// waits in the output register while the next item is taken. A result that is still
// waiting holds the following one in ST_FINISH until it is taken. Depends on
// pidwc_pkg, pidwc_mul and pidwc_div.
module pid_controller_windup_clamp #(
    parameter int DATA_WIDTH = pidwc_pkg::DATA_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input items
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // [31:0] target, [63:32] measured, [79:64] dt
    input  logic [pidwc_pkg::IN_TDATA_W-1:0]      s_tdata,
    // [0] req_type: 0 update step, 1 clear integral
    input  logic                                  s_tuser,
    // Result items
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [DATA_WIDTH-1:0] drive, [DATA_WIDTH] saturated, zero padded to bytes
    output logic [((DATA_WIDTH+8)/8)*8-1:0]       m_tdata,
    // Configuration writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pidwc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pidwc_pkg::GAIN_W-1:0]          cfg_data
);

    import pidwc_pkg::*;

    localparam int OUT_TDATA_W = ((DATA_WIDTH + 8) / 8) * 8;
    localparam logic [DATA_WIDTH-1:0] DRV_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] DRV_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_START,
        ST_WAIT_MUL,
        ST_INT_ADD,
        ST_WAIT_LIM,
        ST_CLAMP,
        ST_START_I,
        ST_WAIT_END,
        ST_SUM,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    // Configuration and long-lived state.
    logic [GAIN_W-1:0]     p_gain_reg, i_gain_reg, d_gain_reg, windup_gain_reg;
    logic [INT_W-1:0]      integral_reg;
    logic [MEAS_W-1:0]     last_reg;
    logic                  m_tvalid_reg;
    logic [DATA_WIDTH-1:0] drive_reg;
    logic                  sat_reg;

    // Per-item datapath registers.
    logic [TGT_W-1:0]  tgt_reg;
    logic [MEAS_W-1:0] cur_reg;
    logic [DT_W-1:0]   dt_reg;
    logic [ERR_W-1:0]  err_reg, diff_reg;
    logic [ETRM_W-1:0] eterm_reg;
    logic [SUM_W-1:0]  pterm_reg, iterm_reg, dterm_reg, sum_reg;
    logic [INT_W-1:0]  imag_reg;
    logic [LIM_W-1:0]  lim_reg;
    logic              i_neg_reg;

    // Combinational values.
    logic                  s_accept, out_free, mul_all_done, end_done;
    logic [ERR_W-1:0]      err_calc, diff_calc, err_mag, diff_mag;
    logic [DT_W-1:0]       dt_div;
    logic [ETRM_W-1:0]     emag_ext, eterm_calc, int_sum;
    logic [INT_W-1:0]      int_sat, imag_calc, lim_ext, lim_neg;
    logic [LIM_W-1:0]      lim_calc;
    logic                  clamp_hit;
    logic [SUM_W-1:0]      pmag_ext, pterm_calc, imag_ext, iterm_calc;
    logic [DQ_W:0]         dq_mag;
    logic [SUM_W-1:0]      dmag_ext, dterm_calc, sum_calc;
    logic                  sum_fits;
    logic [DATA_WIDTH-1:0] drive_calc;

    // Serial unit handshakes and results.
    logic                     start_mul, start_div_d, start_mul_i;
    logic                     busy_e, busy_p, busy_d, busy_i, busy_lim, busy_dd;
    logic [ERR_W+DT_W-1:0]    prod_e;
    logic [ERR_W+GAIN_W-1:0]  prod_p, prod_d;
    logic [INT_W+GAIN_W-1:0]  prod_i;
    logic [LIM_W-1:0]         lim_q;
    logic                     lim_ovf;
    logic [DQ_W-1:0]          dq_q;
    logic                     dq_ovf;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = ~m_tvalid_reg | m_tready;

    // Error, change of measurement and their magnitudes.
    always_comb
    begin
        err_calc  = {tgt_reg[TGT_W-1], tgt_reg} - {cur_reg[MEAS_W-1], cur_reg};
        diff_calc = {cur_reg[MEAS_W-1], cur_reg} - {last_reg[MEAS_W-1], last_reg};
        err_mag   = err_reg[ERR_W-1] ? (~err_reg + 1'b1) : err_reg;
        diff_mag  = diff_reg[ERR_W-1] ? (~diff_reg + 1'b1) : diff_reg;
        dt_div    = (dt_reg == '0) ? DT_W'(1) : dt_reg;
    end

    // Signed error * dt, proportional term, and integral update with saturation.
    always_comb
    begin
        emag_ext   = {1'b0, prod_e};
        eterm_calc = err_reg[ERR_W-1] ? (~emag_ext + 1'b1) : emag_ext;
        pmag_ext   = SUM_W'(prod_p[ERR_W+GAIN_W-1:16]);
        pterm_calc = err_reg[ERR_W-1] ? (~pmag_ext + 1'b1) : pmag_ext;
        int_sum    = {{2{integral_reg[INT_W-1]}}, integral_reg} + eterm_reg;
        if (int_sum[ETRM_W-1:INT_W-1] == '0 || int_sum[ETRM_W-1:INT_W-1] == '1)
        begin
            int_sat = int_sum[INT_W-1:0];
        end
        else if (int_sum[ETRM_W-1])
        begin
            int_sat = INT_MIN;
        end
        else
        begin
            int_sat = INT_MAX;
        end
    end

    // Windup limit and clamp.
    always_comb
    begin
        lim_calc  = lim_ovf ? '1 : lim_q;
        imag_calc = integral_reg[INT_W-1] ? (~integral_reg + 1'b1) : integral_reg;
        lim_ext   = {1'b0, lim_reg};
        lim_neg   = ~lim_ext + 1'b1;
        clamp_hit = (i_gain_reg != '0) && (imag_reg > lim_ext);
    end

    // Integral and derivative terms with sign, then the sum and output saturation.
    always_comb
    begin
        imag_ext   = SUM_W'(prod_i[INT_W+GAIN_W-1:GAIN_W]);
        iterm_calc = i_neg_reg ? (~imag_ext + 1'b1) : imag_ext;
        dq_mag     = dq_ovf ? TERM_CAP : {1'b0, dq_q};
        dmag_ext   = SUM_W'(dq_mag);
        dterm_calc = diff_reg[ERR_W-1] ? (~dmag_ext + 1'b1) : dmag_ext;
        sum_calc   = pterm_reg + iterm_reg - dterm_reg;
        sum_fits   = (&sum_reg[SUM_W-1:DATA_WIDTH-1]) | ~(|sum_reg[SUM_W-1:DATA_WIDTH-1]);
        if (sum_fits)
        begin
            drive_calc = sum_reg[DATA_WIDTH-1:0];
        end
        else if (sum_reg[SUM_W-1])
        begin
            drive_calc = DRV_MIN;
        end
        else
        begin
            drive_calc = DRV_MAX;
        end
    end

    // Unit start pulses.
    assign mul_all_done = ~busy_e & ~busy_p & ~busy_d;
    assign end_done     = ~busy_i & ~busy_dd;
    assign start_mul    = (state_reg == ST_START);
    assign start_div_d  = (state_reg == ST_WAIT_MUL) && mul_all_done;
    assign start_mul_i  = (state_reg == ST_START_I);

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept && !s_tuser)
                begin
                    state_next = ST_ERR;
                end
            end
            ST_ERR:      state_next = ST_START;
            ST_START:    state_next = ST_WAIT_MUL;
            ST_WAIT_MUL:
            begin
                if (mul_all_done)
                begin
                    state_next = ST_INT_ADD;
                end
            end
            ST_INT_ADD:  state_next = ST_WAIT_LIM;
            ST_WAIT_LIM:
            begin
                if (!busy_lim)
                begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP:    state_next = ST_START_I;
            ST_START_I:  state_next = ST_WAIT_END;
            ST_WAIT_END:
            begin
                if (end_done)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:      state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // State, configuration, controller state and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            p_gain_reg      <= '0;
            i_gain_reg      <= '0;
            d_gain_reg      <= '0;
            windup_gain_reg <= '0;
            integral_reg    <= '0;
            last_reg        <= '0;
            m_tvalid_reg    <= 1'b0;
            drive_reg       <= '0;
            sat_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_P_GAIN:      p_gain_reg      <= cfg_data;
                    REG_I_GAIN:      i_gain_reg      <= cfg_data;
                    REG_D_GAIN:      d_gain_reg      <= cfg_data;
                    REG_WINDUP_GAIN: windup_gain_reg <= cfg_data;
                    default:         ;
                endcase
            end

            if (state_reg == ST_IDLE && s_accept && s_tuser)
            begin
                integral_reg <= '0;
            end
            else if (state_reg == ST_INT_ADD)
            begin
                integral_reg <= int_sat;
            end
            else if (state_reg == ST_CLAMP && clamp_hit)
            begin
                integral_reg <= i_neg_reg ? lim_neg : lim_ext;
            end

            if (state_reg == ST_ERR)
            begin
                last_reg <= cur_reg;
            end

            if (state_reg == ST_FINISH && out_free)
            begin
                m_tvalid_reg <= 1'b1;
                drive_reg    <= drive_calc;
                sat_reg      <= ~sum_fits;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Per-item datapath registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_accept)
        begin
            tgt_reg <= s_tdata[TGT_W-1:0];
            cur_reg <= s_tdata[TGT_W+MEAS_W-1:TGT_W];
            dt_reg  <= s_tdata[IN_TDATA_W-1:TGT_W+MEAS_W];
        end
        if (state_reg == ST_ERR)
        begin
            err_reg  <= err_calc;
            diff_reg <= diff_calc;
        end
        if (start_div_d)
        begin
            eterm_reg <= eterm_calc;
            pterm_reg <= pterm_calc;
        end
        if (state_reg == ST_WAIT_LIM && !busy_lim)
        begin
            lim_reg   <= lim_calc;
            imag_reg  <= imag_calc;
            i_neg_reg <= integral_reg[INT_W-1];
        end
        else if (state_reg == ST_CLAMP && clamp_hit)
        begin
            imag_reg <= lim_ext;
        end
        if (state_reg == ST_WAIT_END && end_done)
        begin
            iterm_reg <= iterm_calc;
            dterm_reg <= dterm_calc;
        end
        if (state_reg == ST_SUM)
        begin
            sum_reg <= sum_calc;
        end
    end

    // |error| * dt for the integral.
    pidwc_mul #(.A_W(ERR_W), .B_W(DT_W)) u_mul_e (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_mul),
        .a     (err_mag),
        .b     (dt_reg),
        .busy  (busy_e),
        .prod  (prod_e)
    );

    // |error| * p_gain.
    pidwc_mul #(.A_W(ERR_W), .B_W(GAIN_W)) u_mul_p (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_mul),
        .a     (err_mag),
        .b     (p_gain_reg),
        .busy  (busy_p),
        .prod  (prod_p)
    );

    // |change of measurement| * d_gain.
    pidwc_mul #(.A_W(ERR_W), .B_W(GAIN_W)) u_mul_d (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_mul),
        .a     (diff_mag),
        .b     (d_gain_reg),
        .busy  (busy_d),
        .prod  (prod_d)
    );

    // |integral| * i_gain.
    pidwc_mul #(.A_W(INT_W), .B_W(GAIN_W)) u_mul_i (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_mul_i),
        .a     (imag_reg),
        .b     (i_gain_reg),
        .busy  (busy_i),
        .prod  (prod_i)
    );

    // Windup limit: windup_gain * 2^32 / i_gain.
    pidwc_div #(.N_W(2*GAIN_W), .D_W(GAIN_W), .Q_W(LIM_W)) u_div_lim (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_mul),
        .dividend ({windup_gain_reg, {GAIN_W{1'b0}}}),
        .divisor  (i_gain_reg),
        .busy     (busy_lim),
        .quot     (lim_q),
        .ovf      (lim_ovf)
    );

    // Derivative product divided by dt.
    pidwc_div #(.N_W(2*GAIN_W), .D_W(DT_W), .Q_W(DQ_W)) u_div_d (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_div_d),
        .dividend (prod_d[2*GAIN_W-1:0]),
        .divisor  (dt_div),
        .busy     (busy_dd),
        .quot     (dq_q),
        .ovf      (dq_ovf)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TDATA_W'({sat_reg, drive_reg});

endmodule

// ===== rtl/core/pidwc_checker.sv =====
// Port-level checks for the PID controller, attached to the top level by bind.
// Depends on pidwc_pkg and the assertion macros header.
`include "pid_controller_windup_clamp_macros.svh"

module pidwc_checker #(
    parameter int DATA_WIDTH = pidwc_pkg::DATA_WIDTH_DEF
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [((DATA_WIDTH+8)/8)*8-1:0] m_tdata
);

    import pidwc_pkg::*;

    localparam logic [DATA_WIDTH-1:0] DRV_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] DRV_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // A stalled result holds.
    `PIDWC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // An update transfer starts work, so the input side closes next cycle.
    `PIDWC_ASSERT_NEXT(a_update_busy, s_tvalid && s_tready && !s_tuser, !s_tready, "input open after update transfer")

    // A clear transfer finishes at once and the input side stays open.
    `PIDWC_ASSERT_NEXT(a_clear_quick, s_tvalid && s_tready && s_tuser, s_tready, "input closed after clear transfer")

    // A saturated result sits at one of the two range limits.
    `PIDWC_ASSERT_SAME(a_sat_limit, m_tvalid && m_tdata[DATA_WIDTH], m_tdata[DATA_WIDTH-1:0] == DRV_MAX || m_tdata[DATA_WIDTH-1:0] == DRV_MIN, "saturated flag without limit value")

endmodule

bind pid_controller_windup_clamp pidwc_checker #(.DATA_WIDTH(DATA_WIDTH)) u_pidwc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
